// ----- rtl/mbce_pkg.sv -----
package mbce_pkg;

    // Field and register widths
    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned COL_W        = 8;
    localparam int unsigned ROW_W        = 12;
    localparam int unsigned PB_W         = 3;
    localparam int unsigned PITCH_W      = 16;
    localparam int unsigned POS_W        = 12;
    localparam int unsigned BPR_W        = 9;
    localparam int unsigned NROWS_W      = 13;
    localparam int unsigned RGB_W        = 24;
    localparam int unsigned CFG_IDX_W    = 4;
    localparam int unsigned CFG_DATA_W   = 24;
    localparam int unsigned PIX_PER_BYTE = 8;
    localparam int unsigned CNT_W        = 3;

    localparam logic [CNT_W-1:0]   LAST_PIXEL = CNT_W'(PIX_PER_BYTE - 1);
    localparam logic [BPR_W-1:0]   MAX_BPR    = BPR_W'(256);
    localparam logic [NROWS_W-1:0] MAX_ROWS   = NROWS_W'(4096);

    // Register reset values
    localparam logic [PB_W-1:0]    RST_PIXEL_BYTES = PB_W'(4);
    localparam logic [PITCH_W-1:0] RST_ROW_PITCH   = PITCH_W'(4096);
    localparam logic [POS_W-1:0]   RST_LEFT_COLUMN = '0;
    localparam logic [POS_W-1:0]   RST_TOP_ROW     = '0;
    localparam logic [BPR_W-1:0]   RST_BPR         = BPR_W'(1);
    localparam logic [NROWS_W-1:0] RST_ROWS        = NROWS_W'(16);
    localparam logic [RGB_W-1:0]   RST_FG_RGB      = RGB_W'(24'hFF_FFFF);
    localparam logic [RGB_W-1:0]   RST_BG_RGB      = '0;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_BYTES    = 4'd0,
        REG_ROW_PITCH      = 4'd1,
        REG_LEFT_COLUMN    = 4'd2,
        REG_TOP_ROW        = 4'd3,
        REG_BYTES_PER_ROW  = 4'd4,
        REG_BITMAP_ROWS    = 4'd5,
        REG_FOREGROUND_RGB = 4'd6,
        REG_BACKGROUND_RGB = 4'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [PB_W-1:0]    pixel_bytes;
        logic [PITCH_W-1:0] row_pitch;
        logic [POS_W-1:0]   left_column;
        logic [POS_W-1:0]   top_row;
        logic [BPR_W-1:0]   bytes_per_row;
        logic [NROWS_W-1:0] bitmap_rows;
        logic [RGB_W-1:0]   foreground_rgb;
        logic [RGB_W-1:0]   background_rgb;
    } t_cfg;

    // One bitmap byte with its placement, handed to the serialiser
    typedef struct packed {
        logic [BYTE_W-1:0] bits;
        logic [ADDR_W-1:0] addr;
        logic              end_bmp;
    } t_job;

endpackage

// ----- rtl/mono_bitmap_colour_expander.sv -----
// Monochrome bitmap colour expander.
//
// Input channel: one bitmap byte per beat (i_in_valid / o_in_stall), bit 7 is
// the leftmost pixel. Each byte gives eight pixel beats on the output channel
// (o_out_valid / i_out_stall): frame buffer byte offset, blue, green, red, a
// flag on the eighth pixel of the byte and a flag on the final bitmap pixel.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// o_cfg_ready is always high. Write registers only while no pixels are pending.
//
// The first pixel of a byte passes through the byte register and then the
// result register after the byte is accepted. Output runs at one pixel per
// cycle while the receiver does not stall, set by the single output beat per
// cycle. The next byte is taken in the cycle the last pixel of the current one
// moves into the result register, so bytes stream with no gap.
// Reset clears the position to the start of the bitmap and loads the register
// defaults. While the receiver stalls, the result register holds its beat and
// the serialiser waits; o_in_stall stays high until the held byte is drained.
module mono_bitmap_colour_expander (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mbce_pkg::BYTE_W-1:0]     i_bitmap_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mbce_pkg::ADDR_W-1:0]     o_byte_offset,
    output logic [7:0]                      o_blue,
    output logic [7:0]                      o_green,
    output logic [7:0]                      o_red,
    output logic                            o_last_of_byte,
    output logic                            o_end_of_bitmap,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbce_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mbce_pkg::*;

    t_cfg cfg;
    t_job job;
    logic ser_ready;
    logic take;

    assign o_in_stall = !ser_ready;
    assign take       = i_in_valid && ser_ready;

    mbce_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mbce_addr_gen u_addr_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_take  (take),
        .i_bits  (i_bitmap_byte),
        .o_job   (job)
    );

    mbce_pixel_ser u_pixel_ser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_take          (take),
        .i_job           (job),
        .o_ready         (ser_ready),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_byte_offset   (o_byte_offset),
        .o_blue          (o_blue),
        .o_green         (o_green),
        .o_red           (o_red),
        .o_last_of_byte  (o_last_of_byte),
        .o_end_of_bitmap (o_end_of_bitmap)
    );

endmodule

// ----- rtl/mbce_cfg_regs.sv -----
module mbce_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mbce_pkg::t_cfg                  o_cfg
);
    import mbce_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file, one write beat per cycle; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_bytes    <= RST_PIXEL_BYTES;
            r_cfg.row_pitch      <= RST_ROW_PITCH;
            r_cfg.left_column    <= RST_LEFT_COLUMN;
            r_cfg.top_row        <= RST_TOP_ROW;
            r_cfg.bytes_per_row  <= RST_BPR;
            r_cfg.bitmap_rows    <= RST_ROWS;
            r_cfg.foreground_rgb <= RST_FG_RGB;
            r_cfg.background_rgb <= RST_BG_RGB;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PIXEL_BYTES:    r_cfg.pixel_bytes    <= i_cfg_data[PB_W-1:0];
                REG_ROW_PITCH:      r_cfg.row_pitch      <= i_cfg_data[PITCH_W-1:0];
                REG_LEFT_COLUMN:    r_cfg.left_column    <= i_cfg_data[POS_W-1:0];
                REG_TOP_ROW:        r_cfg.top_row        <= i_cfg_data[POS_W-1:0];
                REG_BYTES_PER_ROW:  r_cfg.bytes_per_row  <= i_cfg_data[BPR_W-1:0];
                REG_BITMAP_ROWS:    r_cfg.bitmap_rows    <= i_cfg_data[NROWS_W-1:0];
                REG_FOREGROUND_RGB: r_cfg.foreground_rgb <= i_cfg_data[RGB_W-1:0];
                REG_BACKGROUND_RGB: r_cfg.background_rgb <= i_cfg_data[RGB_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/mbce_addr_gen.sv -----
module mbce_addr_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbce_pkg::t_cfg              i_cfg,
    input  logic                        i_take,
    input  logic [mbce_pkg::BYTE_W-1:0] i_bits,
    output mbce_pkg::t_job              o_job
);
    import mbce_pkg::*;

    logic               r_at_start;
    logic [ADDR_W-1:0]  r_pixel_addr;
    logic [ADDR_W-1:0]  r_row_start;
    logic [COL_W-1:0]   r_byte_col;
    logic [ROW_W-1:0]   r_row_idx;

    logic [14:0]        col_off;
    logic [27:0]        row_off;
    logic [ADDR_W-1:0]  origin;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  cur_row_start;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [BPR_W-1:0]   eff_bytes;
    logic [NROWS_W-1:0] eff_rows;
    logic               last_col;
    logic               last_row;
    logic [ADDR_W-1:0]  byte_step;
    logic [ADDR_W-1:0]  next_row_start;

    // Start position of the bitmap from the live registers
    assign col_off = 15'(i_cfg.left_column) * 15'(i_cfg.pixel_bytes);
    assign row_off = 28'(i_cfg.top_row) * 28'(i_cfg.row_pitch);
    assign origin  = {17'b0, col_off} + {4'b0, row_off};

    assign cur_addr      = r_at_start ? origin : r_pixel_addr;
    assign cur_row_start = r_at_start ? origin : r_row_start;
    assign cur_col       = r_at_start ? '0 : r_byte_col;
    assign cur_row       = r_at_start ? '0 : r_row_idx;

    // Counts clamped to their legal range
    always_comb begin
        if (i_cfg.bytes_per_row == '0) begin
            eff_bytes = BPR_W'(1);
        end else if (i_cfg.bytes_per_row > MAX_BPR) begin
            eff_bytes = MAX_BPR;
        end else begin
            eff_bytes = i_cfg.bytes_per_row;
        end
        if (i_cfg.bitmap_rows == '0) begin
            eff_rows = NROWS_W'(1);
        end else if (i_cfg.bitmap_rows > MAX_ROWS) begin
            eff_rows = MAX_ROWS;
        end else begin
            eff_rows = i_cfg.bitmap_rows;
        end
    end

    assign last_col = ({1'b0, cur_col} + BPR_W'(1)) >= eff_bytes;
    assign last_row = ({1'b0, cur_row} + NROWS_W'(1)) >= eff_rows;

    assign byte_step      = {{(ADDR_W-PB_W-3){1'b0}}, i_cfg.pixel_bytes, 3'b000};
    assign next_row_start = cur_row_start + {{(ADDR_W-PITCH_W){1'b0}}, i_cfg.row_pitch};

    assign o_job.bits    = i_bits;
    assign o_job.addr    = cur_addr;
    assign o_job.end_bmp = last_col && last_row;

    // Position state, advanced once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start   <= 1'b1;
            r_pixel_addr <= '0;
            r_row_start  <= '0;
            r_byte_col   <= '0;
            r_row_idx    <= '0;
        end else if (i_take) begin
            priority if (!last_col) begin
                r_at_start   <= 1'b0;
                r_byte_col   <= cur_col + COL_W'(1);
                r_row_idx    <= cur_row;
                r_row_start  <= cur_row_start;
                r_pixel_addr <= cur_addr + byte_step;
            end else if (last_row) begin
                r_at_start   <= 1'b1;
                r_byte_col   <= '0;
                r_row_idx    <= '0;
            end else begin
                r_at_start   <= 1'b0;
                r_byte_col   <= '0;
                r_row_idx    <= cur_row + ROW_W'(1);
                r_row_start  <= next_row_start;
                r_pixel_addr <= next_row_start;
            end
        end
    end

endmodule

// ----- rtl/mbce_pixel_ser.sv -----
module mbce_pixel_ser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbce_pkg::t_cfg              i_cfg,
    input  logic                        i_take,
    input  mbce_pkg::t_job              i_job,
    output logic                        o_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mbce_pkg::ADDR_W-1:0] o_byte_offset,
    output logic [7:0]                  o_blue,
    output logic [7:0]                  o_green,
    output logic [7:0]                  o_red,
    output logic                        o_last_of_byte,
    output logic                        o_end_of_bitmap
);
    import mbce_pkg::*;

    // Byte register
    logic              r_active;
    logic [BYTE_W-1:0] r_bits;
    logic [ADDR_W-1:0] r_addr;
    logic              r_end;
    logic [CNT_W-1:0]  r_cnt;

    // Result register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [RGB_W-1:0]  r_out_rgb;
    logic              r_out_last;
    logic              r_out_end;

    logic              out_free;
    logic              last_pix;
    logic [RGB_W-1:0]  pix_rgb;

    assign out_free = !r_out_valid || !i_out_stall;
    assign last_pix = (r_cnt == LAST_PIXEL);
    assign o_ready  = !r_active || (out_free && last_pix);
    assign pix_rgb  = r_bits[BYTE_W-1] ? i_cfg.foreground_rgb : i_cfg.background_rgb;

    // Byte register: load a new byte or step to the next pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_take) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (r_active && out_free) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (last_pix) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_bits <= i_job.bits;
            r_addr <= i_job.addr;
            r_end  <= i_job.end_bmp;
        end else if (r_active && out_free) begin
            r_bits <= {r_bits[BYTE_W-2:0], 1'b0};
            r_addr <= r_addr + {{(ADDR_W-PB_W){1'b0}}, i_cfg.pixel_bytes};
        end
    end

    // Result register, refilled whenever the receiver takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_active) begin
            r_out_addr <= r_addr;
            r_out_rgb  <= pix_rgb;
            r_out_last <= last_pix;
            r_out_end  <= last_pix && r_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_offset   = r_out_addr;
    assign o_blue          = r_out_rgb[7:0];
    assign o_green         = r_out_rgb[15:8];
    assign o_red           = r_out_rgb[23:16];
    assign o_last_of_byte  = r_out_last;
    assign o_end_of_bitmap = r_out_end;

endmodule

// ----- rtl/mbce_checker.sv -----
module mbce_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [mbce_pkg::ADDR_W-1:0]     o_byte_offset,
    input logic                            o_last_of_byte,
    input logic                            o_end_of_bitmap
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_offset))
        else $error("stalled result beat changed");

    // An accepted byte blocks the input until its pixels drain
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again during expansion");

    // A valid result beat follows an accepted byte via the byte and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##2 o_out_valid)
        else $error("no pixel after accepted byte");

    // End of bitmap only on the last pixel of a byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_bitmap |-> o_last_of_byte)
        else $error("end of bitmap off a byte boundary");

endmodule

bind mono_bitmap_colour_expander mbce_checker u_mbce_checker (.*);

// ----- dv/tb_mono_bitmap_colour_expander.sv -----
`timescale 1ns / 100ps

module tb_mono_bitmap_colour_expander;
    import mbce_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_TARGET = 450;
    localparam int CALM_TAIL     = 60;
    localparam int PRINT_CAP     = 40;
    localparam int END_SETTLE    = 8;

    // Indexes outside the register map, written to prove they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 4'd15;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic              last_px;
        logic              end_bmp;
    } t_pixel;

    // Predicts the pixel writes of each bitmap byte and checks the beats
    class pixel_write_model;
        logic [PB_W-1:0]    pix_bytes;
        logic [PITCH_W-1:0] pitch;
        logic [POS_W-1:0]   left;
        logic [POS_W-1:0]   top;
        logic [BPR_W-1:0]   bpr;
        logic [NROWS_W-1:0] rows;
        logic [RGB_W-1:0]   fg;
        logic [RGB_W-1:0]   bg;
        bit                 at_start;
        logic [ADDR_W-1:0]  pix_addr;
        logic [ADDR_W-1:0]  row_addr;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        t_pixel             pending_pixels[$];
        int                 errors;
        int                 bytes_in;
        int                 pixels_seen;
        int                 bitmaps_done;

        function new();
            pix_bytes    = RST_PIXEL_BYTES;
            pitch        = RST_ROW_PITCH;
            left         = RST_LEFT_COLUMN;
            top          = RST_TOP_ROW;
            bpr          = RST_BPR;
            rows         = RST_ROWS;
            fg           = RST_FG_RGB;
            bg           = RST_BG_RGB;
            at_start     = 1'b1;
            pix_addr     = '0;
            row_addr     = '0;
            col          = '0;
            row          = '0;
            errors       = 0;
            bytes_in     = 0;
            pixels_seen  = 0;
            bitmaps_done = 0;
        endfunction

        function int cols_eff();
            if (bpr == '0) return 1;
            if (bpr > MAX_BPR) return int'(MAX_BPR);
            return int'(bpr);
        endfunction

        function int rows_eff();
            if (rows == '0) return 1;
            if (rows > MAX_ROWS) return int'(MAX_ROWS);
            return int'(rows);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PIXEL_BYTES:    pix_bytes = data[PB_W-1:0];
                REG_ROW_PITCH:      pitch     = data[PITCH_W-1:0];
                REG_LEFT_COLUMN:    left      = data[POS_W-1:0];
                REG_TOP_ROW:        top       = data[POS_W-1:0];
                REG_BYTES_PER_ROW:  bpr       = data[BPR_W-1:0];
                REG_BITMAP_ROWS:    rows      = data[NROWS_W-1:0];
                REG_FOREGROUND_RGB: fg        = data[RGB_W-1:0];
                REG_BACKGROUND_RGB: bg        = data[RGB_W-1:0];
                default: ;
            endcase
        endfunction

        // Bytes still needed to reach the end of the bitmap from here
        function int bytes_to_end();
            int eb;
            int er;
            int in_row;
            int later;
            eb     = cols_eff();
            er     = rows_eff();
            in_row = (int'(col) + 1 >= eb) ? 1 : eb - int'(col);
            later  = (int'(row) + 1 >= er) ? 0 : (er - int'(row) - 1) * eb;
            return in_row + later;
        endfunction

        function int outstanding();
            return pending_pixels.size();
        endfunction

        function void take_byte(logic [BYTE_W-1:0] bits);
            t_pixel           px;
            logic [RGB_W-1:0] rgb;
            bit               last_col;
            bit               last_row;
            if (at_start) begin
                pix_addr = ADDR_W'(left) * ADDR_W'(pix_bytes) + ADDR_W'(top) * ADDR_W'(pitch);
                row_addr = pix_addr;
                col      = '0;
                row      = '0;
                at_start = 1'b0;
            end
            last_col = (int'(col) + 1) >= cols_eff();
            last_row = (int'(row) + 1) >= rows_eff();
            for (int i = 0; i < PIX_PER_BYTE; i++) begin
                rgb        = bits[BYTE_W-1-i] ? fg : bg;
                px.offset  = pix_addr;
                px.blue    = rgb[7:0];
                px.green   = rgb[15:8];
                px.red     = rgb[23:16];
                px.last_px = (i == PIX_PER_BYTE - 1);
                px.end_bmp = (i == PIX_PER_BYTE - 1) && last_col && last_row;
                pending_pixels.push_back(px);
                pix_addr   = pix_addr + ADDR_W'(pix_bytes);
            end
            // advance along the row, to the next row, or back to the start
            if (!last_col) begin
                col = col + COL_W'(1);
            end else if (last_row) begin
                at_start = 1'b1;
                col      = '0;
                row      = '0;
                bitmaps_done++;
            end else begin
                col      = '0;
                row      = row + ROW_W'(1);
                row_addr = row_addr + ADDR_W'(pitch);
                pix_addr = row_addr;
            end
            bytes_in++;
        endfunction

        task report(string what, logic [ADDR_W-1:0] exp_val, logic [ADDR_W-1:0] got_val);
            if (errors < PRINT_CAP)
                $display("MISMATCH %s: expected %h, got %h", what, exp_val, got_val);
            errors++;
        endtask

        task check_pixel(t_pixel got);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                report("pixel beat with nothing pending (offset)", '0, got.offset);
            end else begin
                want = pending_pixels.pop_front();
                pixels_seen++;
                if (got.offset !== want.offset)
                    report("byte_offset", want.offset, got.offset);
                if (got.blue !== want.blue)
                    report("blue", ADDR_W'(want.blue), ADDR_W'(got.blue));
                if (got.green !== want.green)
                    report("green", ADDR_W'(want.green), ADDR_W'(got.green));
                if (got.red !== want.red)
                    report("red", ADDR_W'(want.red), ADDR_W'(got.red));
                if (got.last_px !== want.last_px)
                    report("last_of_byte", ADDR_W'(want.last_px), ADDR_W'(got.last_px));
                if (got.end_bmp !== want.end_bmp)
                    report("end_of_bitmap", ADDR_W'(want.end_bmp), ADDR_W'(got.end_bmp));
            end
        endtask

        task flush_check();
            if (pending_pixels.size() != 0)
                report("pixel writes never seen (count)", '0, ADDR_W'(pending_pixels.size()));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_bitmap_byte;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [ADDR_W-1:0]     o_byte_offset;
    logic [7:0]            o_blue;
    logic [7:0]            o_green;
    logic [7:0]            o_red;
    logic                  o_last_of_byte;
    logic                  o_end_of_bitmap;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pixel_write_model model;
    bit               calm;
    int               cycle_count;
    int               stall_run;
    int               reg_writes;

    mono_bitmap_colour_expander i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_bitmap_byte   (i_bitmap_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_byte_offset   (o_byte_offset),
        .o_blue          (o_blue),
        .o_green         (o_green),
        .o_red           (o_red),
        .o_last_of_byte  (o_last_of_byte),
        .o_end_of_bitmap (o_end_of_bitmap),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mono_bitmap_colour_expander regression: fail");
            $finish;
        end
    end

    // Receiver stall: random bursts, none in the calm tail
    always @(negedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
            stall_run   <= $urandom_range(0, 13);
        end
    end

    // Pixel beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            model.check_pixel({o_byte_offset, o_blue, o_green, o_red,
                               o_last_of_byte, o_end_of_bitmap});
    end

    // One register write beat
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.write_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= CFG_DATA_W'($urandom);
    endtask

    // One bitmap byte beat, then maybe an idle burst
    task automatic feed_byte(logic [BYTE_W-1:0] bits);
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_bitmap_byte <= bits;
        do @(posedge i_clk); while (o_in_stall);
        model.take_byte(bits);
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid    <= 1'b0;
            i_bitmap_byte <= BYTE_W'($urandom);
            repeat ($urandom_range(0, 13)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (model.outstanding() != 0) @(posedge i_clk);
    endtask

    // Random junk above a register's width; the block must drop it
    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int w);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom) << w;
        return v | junk;
    endfunction

    // Mostly small counts, sometimes zero or above the clamp
    function automatic logic [CFG_DATA_W-1:0] pick_count(int w, int span);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return CFG_DATA_W'($urandom_range(span + 1, (1 << w) - 1));
        return CFG_DATA_W'($urandom_range(1, 4));
    endfunction

    task automatic random_setup();
        logic [CFG_DATA_W-1:0] pb;
        pb = ($urandom_range(0, 3) != 0) ? CFG_DATA_W'($urandom_range(3, 4))
                                         : CFG_DATA_W'($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 0) cfg_write(REG_PIXEL_BYTES, with_junk(pb, PB_W));
        if ($urandom_range(0, 1) == 0)
            cfg_write(REG_ROW_PITCH, with_junk(CFG_DATA_W'($urandom_range(0, 65535)), PITCH_W));
        if ($urandom_range(0, 1) == 0)
            cfg_write(REG_LEFT_COLUMN, with_junk(CFG_DATA_W'($urandom_range(0, 4095)), POS_W));
        if ($urandom_range(0, 1) == 0)
            cfg_write(REG_TOP_ROW, with_junk(CFG_DATA_W'($urandom_range(0, 4095)), POS_W));
        if ($urandom_range(0, 1) == 0)
            cfg_write(REG_BYTES_PER_ROW, with_junk(pick_count(BPR_W, 256), BPR_W));
        if ($urandom_range(0, 1) == 0)
            cfg_write(REG_BITMAP_ROWS, with_junk(pick_count(NROWS_W, 4096), NROWS_W));
        if ($urandom_range(0, 1) == 0) cfg_write(REG_FOREGROUND_RGB, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 1) == 0) cfg_write(REG_BACKGROUND_RGB, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 7) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                      CFG_DATA_W'($urandom));
    endtask

    initial begin
        int sent;
        int n;
        model         = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_bitmap_byte = '0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        calm          = 1'b0;
        cycle_count   = 0;
        stall_run     = 0;
        reg_writes    = 0;
        sent          = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Register defaults: two rows of a 16-row bitmap
        feed_byte(8'h00);
        feed_byte(8'hFF);
        drain();

        // Counts shrunk below the position mid-bitmap, then a bitmap at the far corner
        cfg_write(REG_PIXEL_BYTES, 24'd3);
        cfg_write(REG_ROW_PITCH, 24'd65535);
        cfg_write(REG_LEFT_COLUMN, 24'd4095);
        cfg_write(REG_TOP_ROW, 24'd4095);
        cfg_write(REG_BYTES_PER_ROW, 24'd2);
        cfg_write(REG_BITMAP_ROWS, 24'd2);
        feed_byte(8'hAA);
        feed_byte(8'h55);
        feed_byte(8'h80);
        feed_byte(8'h01);
        feed_byte(8'h7F);
        feed_byte(8'hFE);
        drain();

        // Zero pixel size, pitch and counts: every byte is a whole bitmap
        cfg_write(REG_PIXEL_BYTES, 24'd0);
        cfg_write(REG_ROW_PITCH, 24'd0);
        cfg_write(REG_BYTES_PER_ROW, 24'd0);
        cfg_write(REG_BITMAP_ROWS, 24'd0);
        cfg_write(REG_FOREGROUND_RGB, 24'h123456);
        cfg_write(REG_BACKGROUND_RGB, 24'hFFFFFF);
        feed_byte(8'h3C);
        feed_byte(8'hC3);
        drain();

        // Largest pixel size, inverted colours, bitmap cut short by new counts
        cfg_write(REG_PIXEL_BYTES, 24'd7);
        cfg_write(REG_ROW_PITCH, 24'd1);
        cfg_write(REG_LEFT_COLUMN, 24'd0);
        cfg_write(REG_TOP_ROW, 24'd0);
        cfg_write(REG_BYTES_PER_ROW, 24'd3);
        cfg_write(REG_BITMAP_ROWS, 24'd3);
        cfg_write(REG_FOREGROUND_RGB, 24'h000000);
        feed_byte(8'h0F);
        feed_byte(8'hF0);
        feed_byte(8'h99);
        feed_byte(8'h66);
        drain();
        cfg_write(REG_BYTES_PER_ROW, 24'd1);
        cfg_write(REG_BITMAP_ROWS, 24'd1);
        feed_byte(8'h5A);
        drain();

        // Writes to unmapped indexes change nothing
        cfg_write(REG_LAST_UNUSED, 24'hFFFFFF);
        cfg_write(REG_FIRST_UNUSED, 24'h000000);
        feed_byte(8'hA5);
        drain();

        // Clamped byte count: one 256-byte row
        cfg_write(REG_PIXEL_BYTES, 24'd4);
        cfg_write(REG_BYTES_PER_ROW, 24'h0001FF);
        cfg_write(REG_BITMAP_ROWS, 24'd1);
        cfg_write(REG_FOREGROUND_RGB, CFG_DATA_W'($urandom));
        n = model.bytes_to_end();
        repeat (n) feed_byte(BYTE_W'($urandom));
        sent += n;
        drain();

        // Random phases: mostly bitmaps run to their end, some cut off
        while (sent < RANDOM_TARGET) begin
            random_setup();
            n = model.bytes_to_end();
            if (!($urandom_range(0, 3) != 0 && n <= 24))
                n = $urandom_range(1, 10);
            if (sent >= RANDOM_TARGET - CALM_TAIL)
                calm = 1'b1;
            repeat (n) feed_byte(BYTE_W'($urandom));
            sent += n;
            drain();
        end

        repeat (END_SETTLE) @(posedge i_clk);
        model.flush_check();
        $display("Covered %0d bitmap bytes, %0d pixel writes and %0d register writes",
                 model.bytes_in, model.pixels_seen, reg_writes);
        $display("%0d bitmaps ran to their end; %0d mismatches",
                 model.bitmaps_done, model.errors);
        if (model.errors == 0) begin
            $display("mono_bitmap_colour_expander regression: pass");
        end else begin
            $display("mono_bitmap_colour_expander regression: fail");
        end
        $finish;
    end

endmodule
